>>> sv/mciir_pkg.sv
`timescale 1ns / 1ps
// mciir_pkg: widths, register indexes, word types and rounding constants
// for the multichannel iir filter; no dependencies

package mciir_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int CH_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 4;
    localparam int FRAC_W     = 30;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 4;

    localparam logic [CFG_IDX_W-1:0] REG_B0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A1       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CH_COUNT = 3'd5;

    localparam logic signed [COEF_W-1:0] B0_RESET       = 32'sh4000_0000;
    localparam logic [CNT_W-1:0]         CH_COUNT_RESET = 4'd2;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd536870912);

    localparam logic signed [ACC_W-FRAC_W-1:0] SAMPLE_MAX = 30'sd8388607;
    localparam logic signed [ACC_W-FRAC_W-1:0] SAMPLE_MIN = -30'sd8388608;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [CH_W-1:0]            chan_t;

    typedef struct packed {
        sample_t x;
        chan_t   ch;
        logic    eof;
        logic    bad;
    } meta_t;

endpackage

>>> sv/mciir_if.sv
`timescale 1ns / 1ps
// mciir_in_if / mciir_out_if: valid-ready channels for input and result words
// depends on mciir_pkg

interface mciir_in_if;
    logic                    valid;
    logic                    ready;
    mciir_pkg::sample_t      sample_in;
    mciir_pkg::chan_t        channel;
    logic                    end_of_frame;

    modport source (output valid, sample_in, channel, end_of_frame, input ready);
    modport sink (input valid, sample_in, channel, end_of_frame, output ready);
endinterface

interface mciir_out_if;
    logic                    valid;
    logic                    ready;
    mciir_pkg::sample_t      filtered_sample;
    mciir_pkg::chan_t        out_channel;
    logic                    frame_end_out;
    logic                    bad_channel;

    modport source (output valid, filtered_sample, out_channel, frame_end_out, bad_channel,
                    input ready);
    modport sink (input valid, filtered_sample, out_channel, frame_end_out, bad_channel,
                  output ready);
endinterface

>>> sv/multichannel_iir_filter.sv
`timescale 1ns / 1ps
// multichannel_iir_filter: direct-form-I biquad over interleaved channels
// path: an accepted word moves through the stage registers m1 to m4, then into the output register
// throughput: one word per cycle while channels differ and the output is not stalled; a word
// whose channel is still in the four-stage read-modify-write loop waits until that word has left it
// reset: coefficients to defaults, history valid bits cleared at once, no clearing pass
// depends on mciir_pkg, mciir_if, mciir_hist_mem

module multichannel_iir_filter #(
    parameter int ORDER        = 2,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mciir_in_if.sink                            in_stream,
    mciir_out_if.source                         out_stream,
    input  logic                                cfg_we,
    input  logic [mciir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mciir_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW    = mciir_pkg::SAMPLE_W;
    localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HW    = 2 * ORDER * SW;
    localparam int YW    = mciir_pkg::ACC_W - mciir_pkg::FRAC_W;
    localparam logic [4:0] CH_LIMIT = 5'(MAX_CHANNELS);

    // coefficients and channel count
    mciir_pkg::coef_t                 b0_reg;
    mciir_pkg::coef_t                 coef_b_reg [ORDER];
    mciir_pkg::coef_t                 coef_a_reg [ORDER];
    logic [mciir_pkg::CNT_W-1:0]      ch_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg       <= mciir_pkg::B0_RESET;
            ch_count_reg <= mciir_pkg::CH_COUNT_RESET;
            for (int k = 0; k < ORDER; k++)
            begin
                coef_b_reg[k] <= '0;
                coef_a_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == mciir_pkg::REG_B0)
            begin
                b0_reg <= cfg_data;
            end
            if (cfg_index == mciir_pkg::REG_CH_COUNT)
            begin
                ch_count_reg <= cfg_data[mciir_pkg::CNT_W-1:0];
            end
            for (int k = 0; k < ORDER; k++)
            begin
                if (cfg_index == mciir_pkg::REG_B1 + mciir_pkg::CFG_IDX_W'(k))
                begin
                    coef_b_reg[k] <= cfg_data;
                end
                if (cfg_index == mciir_pkg::REG_A1 + mciir_pkg::CFG_IDX_W'(k))
                begin
                    coef_a_reg[k] <= cfg_data;
                end
            end
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic mv1, mv2, mv3, mv4, free1, free2, free3, free4;
    logic hazard, accept, bad_in;
    mciir_pkg::meta_t m1_reg, m2_reg, m3_reg, m4_reg, meta_in;

    assign mv4   = v4_reg && (!out_valid_reg || out_stream.ready);
    assign free4 = !v4_reg || mv4;
    assign mv3   = v3_reg && free4;
    assign free3 = !v3_reg || mv3;
    assign mv2   = v2_reg && free3;
    assign free2 = !v2_reg || mv2;
    assign mv1   = v1_reg && free2;
    assign free1 = !v1_reg || mv1;

    // same-channel word still in the read-modify-write loop
    assign hazard = (v1_reg && !m1_reg.bad && m1_reg.ch == in_stream.channel)
                 || (v2_reg && !m2_reg.bad && m2_reg.ch == in_stream.channel)
                 || (v3_reg && !m3_reg.bad && m3_reg.ch == in_stream.channel)
                 || (v4_reg && !m4_reg.bad && m4_reg.ch == in_stream.channel);

    assign in_stream.ready = free1 && !hazard;
    assign accept          = in_stream.valid && in_stream.ready;

    assign bad_in = ({1'b0, in_stream.channel} >= ch_count_reg)
                 || ({2'b00, in_stream.channel} >= CH_LIMIT);

    always_comb
    begin
        meta_in.x   = in_stream.sample_in;
        meta_in.ch  = in_stream.channel;
        meta_in.eof = in_stream.end_of_frame;
        meta_in.bad = bad_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= accept || (v1_reg && !mv1);
            v2_reg        <= mv1 || (v2_reg && !mv2);
            v3_reg        <= mv2 || (v3_reg && !mv3);
            v4_reg        <= mv3 || (v4_reg && !mv4);
            out_valid_reg <= mv4 || (out_valid_reg && !out_stream.ready);
        end
    end

    // history memory
    logic [3:0]    ch_in_ext, ch4_ext;
    logic [HW-1:0] hist1, wr_data;
    logic          mem_we;

    assign ch_in_ext = {1'b0, in_stream.channel};
    assign ch4_ext   = {1'b0, m4_reg.ch};
    assign mem_we    = mv4 && !m4_reg.bad;

    mciir_hist_mem #(
        .DEPTH (MAX_CHANNELS),
        .WIDTH (HW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && !bad_in),
        .rd_addr (ch_in_ext[AW-1:0]),
        .rd_data (hist1),
        .wr_en   (mem_we),
        .wr_addr (ch4_ext[AW-1:0]),
        .wr_data (wr_data)
    );

    // datapath
    mciir_pkg::prod_t p0_reg;
    mciir_pkg::prod_t pb_reg [ORDER];
    mciir_pkg::prod_t pa_reg [ORDER];
    mciir_pkg::acc_t  sa_reg, sb_reg, acc_reg, sa_next, sb_next;
    logic [HW-1:0]    h2_reg, h3_reg, h4_reg;
    logic signed [YW-1:0] y_wide;
    mciir_pkg::sample_t   y_sat;
    mciir_pkg::sample_t   out_y_reg;
    mciir_pkg::chan_t     out_ch_reg;
    logic                 out_eof_reg, out_bad_reg;

    always_comb
    begin
        sa_next = mciir_pkg::ACC_W'(p0_reg);
        sb_next = '0;
        for (int k = 0; k < ORDER; k++)
        begin
            sa_next = sa_next + mciir_pkg::ACC_W'(pb_reg[k]);
            sb_next = sb_next + mciir_pkg::ACC_W'(pa_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m1_reg <= meta_in;
        end
        if (mv1)
        begin
            m2_reg <= m1_reg;
            h2_reg <= hist1;
            p0_reg <= b0_reg * m1_reg.x;
            for (int k = 0; k < ORDER; k++)
            begin
                pb_reg[k] <= coef_b_reg[k] * mciir_pkg::sample_t'(hist1[k*SW +: SW]);
                pa_reg[k] <= coef_a_reg[k]
                           * mciir_pkg::sample_t'(hist1[(ORDER+k)*SW +: SW]);
            end
        end
        if (mv2)
        begin
            m3_reg <= m2_reg;
            h3_reg <= h2_reg;
            sa_reg <= sa_next;
            sb_reg <= sb_next;
        end
        if (mv3)
        begin
            m4_reg  <= m3_reg;
            h4_reg  <= h3_reg;
            acc_reg <= sa_reg + sb_reg + mciir_pkg::ROUND_BIAS;
        end
        if (mv4)
        begin
            out_y_reg   <= m4_reg.bad ? '0 : y_sat;
            out_ch_reg  <= m4_reg.ch;
            out_eof_reg <= m4_reg.eof;
            out_bad_reg <= m4_reg.bad;
        end
    end

    // saturate the rounded accumulator
    always_comb
    begin
        y_wide = acc_reg[mciir_pkg::ACC_W-1:mciir_pkg::FRAC_W];
        if (y_wide > mciir_pkg::SAMPLE_MAX)
        begin
            y_sat = mciir_pkg::sample_t'(mciir_pkg::SAMPLE_MAX);
        end
        else if (y_wide < mciir_pkg::SAMPLE_MIN)
        begin
            y_sat = mciir_pkg::sample_t'(mciir_pkg::SAMPLE_MIN);
        end
        else
        begin
            y_sat = y_wide[SW-1:0];
        end
    end

    // shifted history written back
    always_comb
    begin
        wr_data                     = '0;
        wr_data[0 +: SW]            = m4_reg.x;
        wr_data[ORDER*SW +: SW]     = y_sat;
        for (int k = 1; k < ORDER; k++)
        begin
            wr_data[k*SW +: SW]         = h4_reg[(k-1)*SW +: SW];
            wr_data[(ORDER+k)*SW +: SW] = h4_reg[(ORDER+k-1)*SW +: SW];
        end
    end

    assign out_stream.valid           = out_valid_reg;
    assign out_stream.filtered_sample = out_y_reg;
    assign out_stream.out_channel     = out_ch_reg;
    assign out_stream.frame_end_out   = out_eof_reg;
    assign out_stream.bad_channel     = out_bad_reg;

endmodule

>>> sv/mciir_hist_mem.sv
`timescale 1ns / 1ps
// mciir_hist_mem: per-channel history memory, one write and one registered read
// port; entries never written read as zero; no package dependency

module mciir_hist_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 96,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for multichannel_iir_filter, with a biquad predictor
// in a small scoreboard class, random idling on both streams and coefficient phases
// depends on mciir_pkg, mciir_if and the filter rtl

module testbench;

    localparam logic [mciir_pkg::CFG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
    localparam logic [mciir_pkg::CFG_IDX_W-1:0] REG_COEF_A2 = 3'd4;
    localparam logic [mciir_pkg::CFG_IDX_W-1:0] REG_SPARE   = 3'd6;
    localparam int NUM_CH       = 8;
    localparam int PHASE_WORDS  = 400;
    localparam int SETTLE       = 8;
    localparam int MAX_REPORTS  = 100;

    class iir_scoreboard;
        longint      gain_x0;
        longint      gain_x[2];
        longint      gain_y[2];
        int unsigned ch_count;
        longint      x_hist[NUM_CH][2];
        longint      y_hist[NUM_CH][2];
        mciir_pkg::meta_t due_words[$];

        function new();
            gain_x0  = 64'sd1073741824;
            gain_x   = '{0, 0};
            gain_y   = '{0, 0};
            ch_count = 2;
            foreach (x_hist[c, k])
            begin
                x_hist[c][k] = 0;
                y_hist[c][k] = 0;
            end
        endfunction

        function void set_reg(logic [mciir_pkg::CFG_IDX_W-1:0] idx,
                              logic [mciir_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mciir_pkg::REG_B0:       gain_x0   = longint'($signed(data));
                mciir_pkg::REG_B1:       gain_x[0] = longint'($signed(data));
                REG_COEF_B2:             gain_x[1] = longint'($signed(data));
                mciir_pkg::REG_A1:       gain_y[0] = longint'($signed(data));
                REG_COEF_A2:             gain_y[1] = longint'($signed(data));
                mciir_pkg::REG_CH_COUNT: ch_count  = data[mciir_pkg::CNT_W-1:0];
                default:                 ;
            endcase
        endfunction

        function void take_sample(mciir_pkg::sample_t x, mciir_pkg::chan_t ch, logic eof);
            mciir_pkg::meta_t w;
            longint acc;
            longint y;
            w.ch  = ch;
            w.eof = eof;
            if (int'(ch) >= ch_count || int'(ch) >= NUM_CH)
            begin
                w.x   = '0;
                w.bad = 1'b1;
            end
            else
            begin
                acc = gain_x0 * longint'(x);
                for (int k = 0; k < 2; k++)
                    acc += gain_x[k] * x_hist[ch][k] + gain_y[k] * y_hist[ch][k];
                // round half up, then clamp to the sample range
                y = (acc + (64'sd1 <<< 29)) >>> 30;
                if (y > 64'sd8388607)
                    y = 64'sd8388607;
                if (y < -64'sd8388608)
                    y = -64'sd8388608;
                x_hist[ch][1] = x_hist[ch][0];
                y_hist[ch][1] = y_hist[ch][0];
                x_hist[ch][0] = longint'(x);
                y_hist[ch][0] = y;
                w.x   = mciir_pkg::sample_t'(y);
                w.bad = 1'b0;
            end
            due_words.push_back(w);
        endfunction

        function bit check_word(mciir_pkg::meta_t got, output string why);
            mciir_pkg::meta_t want;
            why = "";
            if (due_words.size() == 0)
            begin
                why = $sformatf("unexpected word on channel %0d", got.ch);
                return 1'b0;
            end
            want = due_words.pop_front();
            if (got.x !== want.x)
                why = {why, $sformatf(" sample %0d want %0d", got.x, want.x)};
            if (got.ch !== want.ch)
                why = {why, $sformatf(" channel %0d want %0d", got.ch, want.ch)};
            if (got.eof !== want.eof)
                why = {why, $sformatf(" frame end %b want %b", got.eof, want.eof)};
            if (got.bad !== want.bad)
                why = {why, $sformatf(" bad channel %b want %b", got.bad, want.bad)};
            return why == "";
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                             cfg_we;
    logic [mciir_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mciir_pkg::CFG_DATA_W-1:0] cfg_data;

    mciir_in_if  in_if ();
    mciir_out_if out_if ();

    iir_scoreboard sb = new();

    int fails = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    multichannel_iir_filter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report(input string what);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("mismatch at %0t:%s", $time, what);
    endtask

    always @(posedge clk)
    begin : monitor
        mciir_pkg::meta_t got;
        string why;
        if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
            sb.take_sample(in_if.sample_in, in_if.channel, in_if.end_of_frame);
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            got.x   = out_if.filtered_sample;
            got.ch  = out_if.out_channel;
            got.eof = out_if.frame_end_out;
            got.bad = out_if.bad_channel;
            if (!sb.check_word(got, why))
                report(why);
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input mciir_pkg::sample_t x, input mciir_pkg::chan_t ch,
                             input logic eof);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_in    <= x;
        in_if.channel      <= ch;
        in_if.end_of_frame <= eof;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
    endtask

    // wait until every word sent has come back, then let the pipe settle
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [mciir_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mciir_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic mciir_pkg::sample_t rand_sample();
        case ($urandom_range(7))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2, 3:    return mciir_pkg::sample_t'(int'($urandom_range(2000)) - 1000);
            4:       return mciir_pkg::sample_t'(int'($urandom_range(32'h40000)) - 32'h20000);
            default: return mciir_pkg::sample_t'($urandom);
        endcase
    endfunction

    function automatic mciir_pkg::coef_t rand_coef();
        case ($urandom_range(5))
            0:       return mciir_pkg::coef_t'($urandom);
            1:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return mciir_pkg::coef_t'(int'($urandom_range(32'h2000_0000))
                                               - 32'sh1000_0000);
        endcase
    endfunction

    task automatic random_config(input int ph);
        logic [mciir_pkg::CFG_DATA_W-1:0] cnt;
        cfg_write(mciir_pkg::REG_B0, rand_coef());
        cfg_write(mciir_pkg::REG_B1, rand_coef());
        cfg_write(REG_COEF_B2, rand_coef());
        cfg_write(mciir_pkg::REG_A1, rand_coef());
        cfg_write(REG_COEF_A2, rand_coef());
        if (ph == 0)
            cnt = 8;
        else if (ph == 1)
            cnt = 1;
        else if ($urandom_range(3) == 0)
            cnt = $urandom;
        else
            cnt = $urandom_range(1, 8);
        cfg_write(mciir_pkg::REG_CH_COUNT, cnt);
        if ($urandom_range(1) == 0)
            cfg_write(REG_SPARE + mciir_pkg::CFG_IDX_W'($urandom_range(1)), $urandom);
    endtask

    // mostly whole frames with channels in turn, some stray words in between
    task automatic random_words(input int words);
        int sent;
        int n;
        sent = 0;
        n = (sb.ch_count > NUM_CH) ? NUM_CH : sb.ch_count;
        while (sent < words)
        begin
            if (n != 0 && $urandom_range(3) != 0)
            begin
                for (int c = 0; c < n; c++)
                begin
                    if ($urandom_range(15) == 0)
                    begin
                        send_word(rand_sample(), mciir_pkg::chan_t'($urandom), 1'($urandom));
                        sent++;
                    end
                    send_word(rand_sample(), mciir_pkg::chan_t'(c), c == n - 1);
                    sent++;
                end
            end
            else
            begin
                send_word(rand_sample(), mciir_pkg::chan_t'($urandom),
                          $urandom_range(7) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        in_if.valid        <= 1'b0;
        in_if.sample_in    <= '0;
        in_if.channel      <= '0;
        in_if.end_of_frame <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: unity gain, two channels
        send_word(24'sh7FFFFF, 3'd0, 1'b0);
        send_word(24'sh800000, 3'd1, 1'b1);
        send_word(-24'sd1, 3'd0, 1'b0);
        send_word(24'sd5, 3'd2, 1'b0);
        send_word(24'sh7FFFFF, 3'd7, 1'b1);
        drain();

        // extreme coefficients, saturation both ways
        cfg_write(mciir_pkg::REG_B0, 32'h7FFF_FFFF);
        cfg_write(mciir_pkg::REG_B1, 32'h8000_0000);
        cfg_write(REG_COEF_B2, 32'h7FFF_FFFF);
        cfg_write(mciir_pkg::REG_A1, 32'h8000_0000);
        cfg_write(REG_COEF_A2, 32'h7FFF_FFFF);
        cfg_write(mciir_pkg::REG_CH_COUNT, 32'd8);
        cfg_write(REG_SPARE, 32'hFFFF_FFFF);
        send_word(24'sh7FFFFF, 3'd7, 1'b0);
        send_word(24'sh800000, 3'd7, 1'b0);
        send_word(24'sh800000, 3'd0, 1'b1);
        send_word(24'sd0, 3'd3, 1'b0);
        drain();

        // half gain: ties round upwards; count above the channel limit
        cfg_write(mciir_pkg::REG_B0, 32'h2000_0000);
        cfg_write(mciir_pkg::REG_B1, 32'h0);
        cfg_write(REG_COEF_B2, 32'h0);
        cfg_write(mciir_pkg::REG_A1, 32'h0);
        cfg_write(REG_COEF_A2, 32'h0);
        cfg_write(mciir_pkg::REG_CH_COUNT, 32'd15);
        send_word(24'sd1, 3'd4, 1'b0);
        send_word(-24'sd1, 3'd4, 1'b0);
        send_word(24'sd3, 3'd5, 1'b0);
        send_word(-24'sd3, 3'd5, 1'b0);
        send_word(24'sh7FFFFF, 3'd7, 1'b1);
        drain();

        // no channels in use
        cfg_write(mciir_pkg::REG_CH_COUNT, 32'd0);
        send_word(24'sd100, 3'd0, 1'b0);
        send_word(24'sd0, 3'd0, 1'b1);
        drain();

        // only the low nibble counts; histories survive coefficient changes
        cfg_write(mciir_pkg::REG_CH_COUNT, 32'h0000_0013);
        cfg_write(mciir_pkg::REG_B1, 32'h4000_0000);
        cfg_write(mciir_pkg::REG_A1, 32'h2000_0000);
        send_word(24'sd1000, 3'd2, 1'b0);
        send_word(24'sd77, 3'd3, 1'b0);
        send_word(-24'sd1000, 3'd2, 1'b0);
        send_word(24'sd0, 3'd0, 1'b1);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 30; end
            endcase
            random_config(ph);
            if (ph == 4)
                hold_left = 300;
            random_words(PHASE_WORDS);
            drain();
        end

        if (fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
